// ----- rtl/pfb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Page framebuffer package
// Shared command codes, controller byte constants and default geometry.
// ----------------------------------------------------------------------------
package pfb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;
    localparam int HEADER_SLOTS      = 5;

    localparam logic [7:0] START_COL_RESET = 8'h04;
    localparam logic [7:0] PAGE_CMD_BASE   = 8'hB0;
    localparam logic [7:0] COL_HIGH_CMD    = 8'h10;
    localparam logic [7:0] COL_LOW_CMD     = 8'h00;
    localparam logic [3:0] NIBBLE_MASK     = 4'hF;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_REFRESH = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        SLOT_PAGE    = 3'd0,
        SLOT_COL_HI  = 3'd1,
        SLOT_COL_LO  = 3'd2,
        SLOT_START_L = 3'd3,
        SLOT_START_H = 3'd4
    } t_hdr_slot;

endpackage
`default_nettype wire

// ----- rtl/pfb_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Page framebuffer store
// Simple dual-port synchronous memory with one write port and one read port.
// The read data is registered and holds its value while no read is issued.
// ----------------------------------------------------------------------------
module pfb_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/page_framebuffer_with_refresh_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Page framebuffer with refresh
// One-bit frame store in pages of eight rows, with pixel access and a
// byte-serial controller refresh stream.
//
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     command, pos_x, pos_y, color
// result    out        o_out_valid / i_out_ready   pixel_value, bus_byte,
//                                                  is_data, frame_done
// config    in         i_cfg_we                    start_column
//
// The store is read when a request is accepted; the result is formed, and any
// pixel update written back, in the execute state once the output is free.
// A clear request additionally sweeps the store, one byte per cycle, over all
// SCREEN_WIDTH * pages bytes before the next request is accepted.
// After reset the same sweep runs over the whole store.
// A result waiting in the output register holds the core in its execute
// state, and no new request is accepted until that result leaves.
// ----------------------------------------------------------------------------
module page_framebuffer_with_refresh_core
    import pfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_pos_x,
    input  wire logic [15:0] i_pos_y,
    input  wire logic        i_color,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_pixel_value,
    output logic [7:0]       o_bus_byte,
    output logic             o_is_data,
    output logic             o_frame_done,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata
);

    localparam int PAGE_COUNT = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int X_W = $clog2(SCREEN_WIDTH);
    localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int SLOT_W = $clog2(SCREEN_WIDTH + HEADER_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SCREEN_WIDTH + HEADER_SLOTS - 1);
    localparam logic [SLOT_W-1:0] SLOT_DATA0 = SLOT_W'(HEADER_SLOTS);
    localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGE_COUNT - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_BYTES - 1);

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic                r_color;
    logic                r_on_screen;
    logic [2:0]          r_bit;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [PAGE_W-1:0]   r_page;
    logic [SLOT_W-1:0]   r_slot;
    logic [7:0]          r_start_col;

    logic                in_fire;
    logic                out_free;
    logic                in_on_screen;
    logic [PAGE_W-1:0]   acc_page;
    logic [X_W-1:0]      acc_col;
    logic [ADDR_W:0]     acc_addr_full;
    logic [ADDR_W-1:0]   acc_addr;
    logic [SLOT_W-1:0]   data_col;
    logic [7:0]          rd_data;
    logic [7:0]          bit_mask;
    logic [7:0]          mod_data;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [7:0]          mem_wdata;
    logic [7:0]          hdr_byte;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !o_out_valid || i_out_ready;

    assign in_on_screen = !i_pos_x[15] && (i_pos_x < 16'(SCREEN_WIDTH))
                       && !i_pos_y[15] && (i_pos_y < 16'(SCREEN_HEIGHT));

    assign data_col = r_slot - SLOT_DATA0;

    always_comb begin
        if (t_cmd'(i_command) == CMD_REFRESH) begin
            acc_page = r_page;
            acc_col  = data_col[X_W-1:0];
        end else begin
            acc_page = i_pos_y[PAGE_W+2:3];
            acc_col  = i_pos_x[X_W-1:0];
        end
    end

    assign acc_addr_full = (ADDR_W+1)'(acc_page) * (ADDR_W+1)'(SCREEN_WIDTH)
                         + (ADDR_W+1)'(acc_col);
    assign acc_addr = acc_addr_full[ADDR_W-1:0];

    assign bit_mask = 8'b1 << r_bit;
    assign mod_data = r_color ? (rd_data | bit_mask) : (rd_data & ~bit_mask);

    always_comb begin
        unique case (t_hdr_slot'(r_slot[2:0]))
            SLOT_PAGE:    hdr_byte = PAGE_CMD_BASE + 8'(r_page);
            SLOT_COL_HI:  hdr_byte = COL_HIGH_CMD;
            SLOT_COL_LO:  hdr_byte = COL_LOW_CMD;
            SLOT_START_L: hdr_byte = {4'h0, r_start_col[3:0] & NIBBLE_MASK};
            SLOT_START_H: hdr_byte = COL_HIGH_CMD | {4'h0, r_start_col[7:4] & NIBBLE_MASK};
            default:      hdr_byte = 8'h00;
        endcase
    end

    always_comb begin
        if (r_state == ST_SWEEP) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = 8'h00;
        end else begin
            mem_we    = (r_state == ST_EXEC) && out_free && (r_cmd == CMD_WRITE)
                     && r_on_screen;
            mem_waddr = r_addr;
            mem_wdata = mod_data;
        end
    end

    pfb_store #(
        .DEPTH  (STORE_BYTES),
        .ADDR_W (ADDR_W),
        .DATA_W (8)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (in_fire),
        .i_raddr (acc_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_col <= START_COL_RESET;
        end else if (i_cfg_we) begin
            r_start_col <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd       <= t_cmd'(i_command);
            r_color     <= i_color;
            r_on_screen <= in_on_screen;
            r_bit       <= i_pos_y[2:0];
            r_addr      <= acc_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_SWEEP;
            r_clr_addr    <= '0;
            r_page        <= '0;
            r_slot        <= '0;
            o_out_valid   <= 1'b0;
            o_pixel_value <= 1'b0;
            o_bus_byte    <= 8'h00;
            o_is_data     <= 1'b0;
            o_frame_done  <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_SWEEP: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_LAST) begin
                        r_clr_addr <= '0;
                        r_state    <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_fire) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        o_out_valid   <= 1'b1;
                        o_pixel_value <= 1'b0;
                        o_bus_byte    <= 8'h00;
                        o_is_data     <= 1'b0;
                        o_frame_done  <= 1'b0;
                        r_state       <= ST_IDLE;
                        unique case (r_cmd)
                            CMD_WRITE: begin
                            end
                            CMD_READ: begin
                                o_pixel_value <= r_on_screen && rd_data[r_bit];
                            end
                            CMD_REFRESH: begin
                                if (r_slot < SLOT_DATA0) begin
                                    o_bus_byte <= hdr_byte;
                                end else begin
                                    o_bus_byte <= rd_data;
                                    o_is_data  <= 1'b1;
                                end
                                if (r_slot == SLOT_LAST) begin
                                    r_slot <= '0;
                                    if (r_page == PAGE_LAST) begin
                                        r_page       <= '0;
                                        o_frame_done <= 1'b1;
                                    end else begin
                                        r_page <= r_page + 1'b1;
                                    end
                                end else begin
                                    r_slot <= r_slot + 1'b1;
                                end
                            end
                            CMD_CLEAR: begin
                                r_state <= ST_SWEEP;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- tb/page_framebuffer_with_refresh_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page framebuffer with refresh: self-checking testbench
// Drives pixel writes, pixel reads, refresh steps and clears through the
// request channel, keeps its own copy of the frame store, refresh position
// and start column, and checks every result field against that copy.
// ----------------------------------------------------------------------------
module page_framebuffer_with_refresh_core_tb;
    import pfb_pkg::*;

    localparam int PAGES       = (SCREEN_HEIGHT_DEF + 7) / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH_DEF * PAGES;
    localparam int PAGE_STEPS  = HEADER_SLOTS + SCREEN_WIDTH_DEF;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        color;
    } pfb_request;

    typedef struct packed {
        logic       pixel;
        logic [7:0] bus;
        logic       data;
        logic       done;
    } pfb_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_command = CMD_READ;
    logic [15:0] i_pos_x = '0;
    logic [15:0] i_pos_y = '0;
    logic        i_color = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_pixel_value;
    logic [7:0]  o_bus_byte;
    logic        o_is_data;
    logic        o_frame_done;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = '0;

    pfb_request  request_fifo[$];
    pfb_result   result_fifo[$];

    logic [7:0]  pixel_bytes[STORE_BYTES];
    int          scan_page;
    int          scan_slot;
    logic [7:0]  start_col;

    bit          in_took = 1'b0;
    bit          calm = 1'b0;
    int          mismatches = 0;
    longint      cycle_count = 0;
    longint      cycle_budget = 6000;

    page_framebuffer_with_refresh_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_color       (i_color),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_value (o_pixel_value),
        .o_bus_byte    (o_bus_byte),
        .o_is_data     (o_is_data),
        .o_frame_done  (o_frame_done),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    task automatic model_request(input pfb_request req, output pfb_result res);
        int         px;
        int         py;
        int         idx;
        logic [7:0] mask;
        bit         visible;
        res = '0;
        px = $signed(req.pos_x);
        py = $signed(req.pos_y);
        visible = px >= 0 && px < SCREEN_WIDTH_DEF && py >= 0 && py < SCREEN_HEIGHT_DEF;
        idx = visible ? px + (py / 8) * SCREEN_WIDTH_DEF : 0;
        mask = 8'd1 << (py & 7);
        case (req.cmd)
            CMD_WRITE: begin
                if (visible) begin
                    if (req.color) pixel_bytes[idx] = pixel_bytes[idx] | mask;
                    else pixel_bytes[idx] = pixel_bytes[idx] & ~mask;
                end
            end
            CMD_READ: begin
                if (visible) res.pixel = |(pixel_bytes[idx] & mask);
            end
            CMD_REFRESH: begin
                case (scan_slot)
                    int'(SLOT_PAGE):    res.bus = PAGE_CMD_BASE + 8'(scan_page);
                    int'(SLOT_COL_HI):  res.bus = COL_HIGH_CMD;
                    int'(SLOT_COL_LO):  res.bus = COL_LOW_CMD;
                    int'(SLOT_START_L): res.bus = {4'h0, start_col[3:0] & NIBBLE_MASK};
                    int'(SLOT_START_H): res.bus = COL_HIGH_CMD | {4'h0, start_col[7:4]};
                    default: begin
                        res.bus = pixel_bytes[scan_page * SCREEN_WIDTH_DEF
                                              + scan_slot - HEADER_SLOTS];
                        res.data = 1'b1;
                    end
                endcase
                scan_slot++;
                if (scan_slot >= PAGE_STEPS) begin
                    scan_slot = 0;
                    scan_page++;
                    if (scan_page >= PAGES) begin
                        scan_page = 0;
                        res.done = 1'b1;
                    end
                end
            end
            default: begin
                foreach (pixel_bytes[i]) pixel_bytes[i] = '0;
            end
        endcase
    endtask

    task automatic check_result(input pfb_result want);
        if (o_pixel_value !== want.pixel) begin
            $error("pixel_value: expected %0d, actual %0d", want.pixel, o_pixel_value);
            mismatches++;
        end
        if (o_bus_byte !== want.bus) begin
            $error("bus_byte: expected 0x%02h, actual 0x%02h", want.bus, o_bus_byte);
            mismatches++;
        end
        if (o_is_data !== want.data) begin
            $error("is_data: expected %0d, actual %0d", want.data, o_is_data);
            mismatches++;
        end
        if (o_frame_done !== want.done) begin
            $error("frame_done: expected %0d, actual %0d", want.done, o_frame_done);
            mismatches++;
        end
    endtask

    task automatic queue_request(input pfb_request req);
        request_fifo.push_back(req);
        cycle_budget += (req.cmd == CMD_CLEAR) ? 1300 : 40;
    endtask

    task automatic push_item(input t_cmd cmd, input int x, input int y, input logic color);
        pfb_request req;
        req.cmd = cmd;
        req.pos_x = 16'(x);
        req.pos_y = 16'(y);
        req.color = color;
        queue_request(req);
    endtask

    function automatic pfb_request rand_request(input int refresh_weight);
        pfb_request req;
        int         pick;
        int         rim_x[6] = '{-1, 0, 127, 128, -32768, 32767};
        int         rim_y[6] = '{-1, 0, 63, 64, -32768, 32767};
        pick = $urandom_range(999);
        if (pick < 12) req.cmd = CMD_CLEAR;
        else if (pick < 12 + refresh_weight) req.cmd = CMD_REFRESH;
        else if (pick < 12 + refresh_weight + (988 - refresh_weight) / 2) req.cmd = CMD_WRITE;
        else req.cmd = CMD_READ;
        pick = $urandom_range(99);
        if (pick < 50) begin
            req.pos_x = 16'($urandom_range(15));
            req.pos_y = 16'($urandom_range(15));
        end else if (pick < 80) begin
            req.pos_x = 16'($urandom_range(SCREEN_WIDTH_DEF - 1));
            req.pos_y = 16'($urandom_range(SCREEN_HEIGHT_DEF - 1));
        end else if (pick < 90) begin
            req.pos_x = 16'(rim_x[$urandom_range(5)]);
            req.pos_y = 16'(rim_y[$urandom_range(5)]);
        end else begin
            req.pos_x = 16'($urandom);
            req.pos_y = 16'($urandom);
        end
        req.color = 1'($urandom_range(1));
        return req;
    endfunction

    task automatic wait_drained();
        while (request_fifo.size() != 0 || i_in_valid || result_fifo.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [7:0] col, input int count, input bit no_gaps);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= col;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        calm = no_gaps;
        repeat (count) queue_request(rand_request(430));
    endtask

    always @(negedge i_clk) begin
        pfb_request nxt;
        if (!i_in_valid || in_took) begin
            if (i_rst_n && request_fifo.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
                nxt = request_fifo.pop_front();
                i_in_valid <= 1'b1;
                i_command <= nxt.cmd;
                i_pos_x <= nxt.pos_x;
                i_pos_y <= nxt.pos_y;
                i_color <= nxt.color;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 18);
    end

    always @(posedge i_clk) begin
        pfb_result predicted;
        in_took = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_cfg_we) start_col = i_cfg_wdata;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_fifo.size() == 0) begin
                $error("result with no request outstanding: bus_byte 0x%02h", o_bus_byte);
                mismatches++;
            end else begin
                check_result(result_fifo.pop_front());
            end
        end
        if (in_took) begin
            model_request({t_cmd'(i_command), i_pos_x, i_pos_y, i_color}, predicted);
            result_fifo.push_back(predicted);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > cycle_budget) begin
            $display("page_framebuffer_with_refresh_core regression: fail");
            $finish;
        end
    end

    initial begin
        foreach (pixel_bytes[i]) pixel_bytes[i] = '0;
        scan_page = 0;
        scan_slot = 0;
        start_col = START_COL_RESET;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_item(CMD_WRITE, 0, 0, 1'b1);
        push_item(CMD_WRITE, 127, 63, 1'b1);
        push_item(CMD_WRITE, 127, 0, 1'b1);
        push_item(CMD_WRITE, 0, 63, 1'b1);
        push_item(CMD_READ, 0, 0, 1'b0);
        push_item(CMD_READ, 127, 63, 1'b0);
        push_item(CMD_WRITE, 128, 0, 1'b1);
        push_item(CMD_WRITE, 0, 64, 1'b1);
        push_item(CMD_WRITE, -1, 5, 1'b1);
        push_item(CMD_WRITE, 5, -1, 1'b1);
        push_item(CMD_READ, 128, 0, 1'b0);
        push_item(CMD_READ, -32768, 32767, 1'b0);
        push_item(CMD_READ, 32767, -32768, 1'b1);
        push_item(CMD_WRITE, 0, 0, 1'b0);
        push_item(CMD_READ, 0, 0, 1'b0);
        repeat (7) push_item(CMD_REFRESH, 0, 0, 1'b0);
        push_item(CMD_CLEAR, 0, 0, 1'b0);
        push_item(CMD_READ, 127, 63, 1'b0);

        run_phase(8'h00, 200, 1'b0);
        run_phase(8'hFF, 200, 1'b0);
        run_phase(8'($urandom_range(1, 254)), 200, 1'b1);
        run_phase(8'($urandom_range(1, 254)), 250, 1'b0);

        wait_drained();
        repeat (40) @(negedge i_clk);
        if (mismatches == 0 && result_fifo.size() == 0) begin
            $display("page_framebuffer_with_refresh_core regression: pass");
        end else begin
            $display("page_framebuffer_with_refresh_core regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pfb_pkg.sv
rtl/pfb_store.sv
rtl/page_framebuffer_with_refresh_core.sv
tb/page_framebuffer_with_refresh_core_tb.sv
